// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
// Depends on: nothing; expects i_clk and i_rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every rising clock edge, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same check, kept running through reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== design/swm_pkg.sv =====
// Package for the sliding window median unit: default sizes.
// Depends on: nothing.
`default_nettype none

package swm_pkg;

    localparam int SWM_WINDOW      = 15;
    localparam int SWM_SAMPLE_BITS = 16;

endpackage

`default_nettype wire

// ===== design/sliding_window_median_unit.sv =====
// Sliding window median unit: circular sample window and rank-count median search.
// Depends on: swm_pkg, assert_macros.svh.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-----------------------
//  in      | i_valid | o_stall | i_sample [SAMPLE_BITS]
//  out     | o_valid | i_stall | o_median [SAMPLE_BITS]
//
// Each beat is written into the window, then the shared rank unit tries one
// candidate after another (stops at the first candidate whose rank covers
// WINDOW/2), and then the found median is loaded into the output.
// Reset clears the window and write slot at once; no clearing pass.
// A pending output beat does not block a new input beat; only the final
// load waits on i_stall.
`default_nettype none

`include "assert_macros.svh"

module sliding_window_median_unit #(
    parameter int WINDOW      = swm_pkg::SWM_WINDOW,
    parameter int SAMPLE_BITS = swm_pkg::SWM_SAMPLE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_median
);
    import swm_pkg::*;

    localparam int IW  = $clog2(WINDOW);
    localparam int CW  = $clog2(WINDOW + 1);
    localparam logic [IW-1:0] LAST = IW'(WINDOW - 1);
    localparam logic [CW-1:0] MID  = CW'(WINDOW / 2);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WAIT} t_state;

    t_state                        r_state, n_state;
    logic signed [SAMPLE_BITS-1:0] r_store [WINDOW];
    logic [IW-1:0]                 r_slot, n_slot;
    logic [IW-1:0]                 r_idx, n_idx;
    logic signed [SAMPLE_BITS-1:0] r_found, n_found;
    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_median, n_median;

    logic                          in_beat;
    logic                          out_free;
    logic                          hit;
    logic signed [SAMPLE_BITS-1:0] cand;
    logic [WINDOW-1:0]             lt_vec, le_vec;
    logic [CW-1:0]                 lt_cnt, le_cnt;

    assign o_stall  = (r_state != ST_IDLE);
    assign in_beat  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_median = r_median;

    // Shared rank unit: compares one candidate against every window lane.
    assign cand = r_store[r_idx];
    always_comb begin
        for (int j = 0; j < WINDOW; j++) begin
            lt_vec[j] = r_store[j] <  cand;
            le_vec[j] = r_store[j] <= cand;
        end
    end
    assign lt_cnt = CW'($countones(lt_vec));
    assign le_cnt = CW'($countones(le_vec));
    // candidate occupies sorted positions lt_cnt .. le_cnt-1
    assign hit    = (lt_cnt <= MID) && (le_cnt > MID);

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_idx       = r_idx;
        n_found     = r_found;
        n_out_valid = r_out_valid && i_stall;
        n_median    = r_median;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_slot  = (r_slot == LAST) ? '0 : r_slot + 1'b1;
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit || r_idx == LAST) begin
                    n_found = cand;
                    n_state = ST_WAIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_median    = r_found;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < WINDOW; k++) begin
                r_store[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (in_beat) begin
                r_store[r_slot] <= i_sample;
            end
        end
        r_found  <= n_found;
        r_median <= n_median;
    end

    `ASSERT_CLK(a_accept_starts_scan, in_beat |=> (r_state == ST_SCAN) && o_stall, "accepted beat did not start a scan")
    `ASSERT_CLK(a_load_sets_valid, (r_state == ST_WAIT) && out_free |=> r_out_valid && (r_median == $past(r_found)), "median not loaded into output")
    `ASSERT_CLK(a_slot_in_range, (r_slot <= LAST) && (r_idx <= LAST), "window index out of range")

endmodule

`default_nettype wire
